// ----- src/mbps_pkg.sv -----
package mbps_pkg;

   // window depth and counter width
   localparam int MAX_PATTERN = 32;
   localparam int COUNT_BITS  = 32;
   localparam int LEN_BITS    = 6;
   localparam int ADDR_BITS   = 6;
   localparam int DATA_BITS   = 64;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // register map, one 64-bit register every eight bytes
   typedef enum logic [2:0] {
      REG_PAT0 = 3'd0,
      REG_PAT1 = 3'd1,
      REG_PAT2 = 3'd2,
      REG_PAT3 = 3'd3,
      REG_CARE = 3'd4,
      REG_LEN  = 3'd5,
      REG_BASE = 3'd6
   } reg_index_type;

   // pattern as the cells see it: entry i faces window position i
   typedef struct packed {
      logic [MAX_PATTERN-1:0][7:0] apat;
      logic [MAX_PATTERN-1:0]      acare;
      logic [LEN_BITS-1:0]         eff_len;
      logic [DATA_BITS-1:0]        base;
   } cfg_type;

endpackage

// ----- src/mbps_cell.sv -----
module mbps_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] byte_in,
   input  logic [7:0] pat_byte,
   input  logic       care,
   output logic [7:0] byte_out,
   output logic       hit
);

   logic [7:0] byte_ff;

   // take the neighbour's byte on every transfer
   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

   // compare the byte this position holds after the shift
   assign hit = !care || (byte_in == pat_byte);

endmodule

// ----- src/mbps_csr.sv -----
module mbps_csr import mbps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output cfg_type              cfg
);

   logic [MAX_PATTERN-1:0][7:0] pat_ff, pat_in;
   logic [31:0]                 care_ff, care_in;
   logic [LEN_BITS-1:0]         len_ff, len_in;
   logic [DATA_BITS-1:0]        base_ff, base_in;
   cfg_type                     cfg_ff, cfg_in;
   logic                        wr;
   logic [2:0]                  idx;
   logic [LEN_BITS-1:0]         eff_len;
   logic [4:0]                  last_pos;
   logic [4:0]                  sel;

   assign wr  = psel && penable && pwrite;
   assign idx = paddr[ADDR_BITS-1:3];

   // register writes
   always_comb begin
      pat_in  = pat_ff;
      care_in = care_ff;
      len_in  = len_ff;
      base_in = base_ff;
      if (wr) begin
         case (reg_index_type'(idx))
            REG_PAT0: pat_in[7:0]   = pwdata;
            REG_PAT1: pat_in[15:8]  = pwdata;
            REG_PAT2: pat_in[23:16] = pwdata;
            REG_PAT3: pat_in[31:24] = pwdata;
            REG_CARE: care_in = pwdata[31:0];
            REG_LEN:  len_in  = pwdata[LEN_BITS-1:0];
            REG_BASE: base_in = pwdata;
            default:  ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (reg_index_type'(idx))
         REG_PAT0: prdata = pat_ff[7:0];
         REG_PAT1: prdata = pat_ff[15:8];
         REG_PAT2: prdata = pat_ff[23:16];
         REG_PAT3: prdata = pat_ff[31:24];
         REG_CARE: prdata = {32'd0, care_ff};
         REG_LEN:  prdata = {{(DATA_BITS-LEN_BITS){1'b0}}, len_ff};
         REG_BASE: prdata = base_ff;
         default:  prdata = '0;
      endcase
   end

   // clamp the length and line the pattern up with the window
   always_comb begin
      eff_len = len_in;
      if (eff_len == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (eff_len > LEN_BITS'(MAX_PATTERN)) begin
         eff_len = LEN_BITS'(MAX_PATTERN);
      end
      last_pos       = 5'(eff_len - LEN_BITS'(1));
      cfg_in.eff_len = eff_len;
      cfg_in.base    = base_in;
      sel            = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         sel              = last_pos - 5'(i);
         cfg_in.apat[i]   = pat_in[sel];
         cfg_in.acare[i]  = (5'(i) <= last_pos) && care_in[sel];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         care_ff <= '1;
         len_ff  <= LEN_BITS'(1);
         base_ff <= '0;
         cfg_ff  <= '{apat: '0, acare: MAX_PATTERN'(1), eff_len: LEN_BITS'(1), base: '0};
      end else begin
         pat_ff  <= pat_in;
         care_ff <= care_in;
         len_ff  <= len_in;
         base_ff <= base_in;
         cfg_ff  <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/masked_byte_pattern_scanner_core.sv -----
// Masked byte pattern scanner.
// Bytes of one memory region enter on the req_ channel in address order, one
// per transfer; req_end_of_region marks the last byte. A row of 32 byte cells
// holds the recent bytes and compares each against the pattern in parallel,
// so the scan takes one byte every cycle and sustains one byte per clock
// unless the output stalls. At the first match in a region one result leaves
// on the rsp_ channel with rsp_match_found set and the address of the first
// matched byte; a region that ends without a match gives one result with
// rsp_match_found clear. A result is valid in the cycle after the transfer
// of the byte that decides it. While a result waits in the output register
// and the receiver stalls, bytes that give no result are still taken; a byte
// that would give a second result waits until the first one is transferred.
// The csr_ port holds the pattern, care mask, length and region base, each a
// 64-bit register at a multiple of eight bytes; a pattern change applies from
// the next byte. Reset restores the register defaults, empties the output
// register and starts a new region; no clearing pass is needed.
module masked_byte_pattern_scanner_core import mbps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_end_of_region,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_match_found,
   output logic [DATA_BITS-1:0] rsp_match_address,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   cfg_type                     cfg;
   logic [MAX_PATTERN-1:0][7:0] chain;
   logic [7:0]                  tail_byte;
   logic [MAX_PATTERN-1:0]      hits;
   logic                        xfer;
   logic                        matched;
   logic                        produce;
   logic [COUNT_BITS-1:0]       seen_ff, seen_in, seen_next;
   logic                        found_ff, found_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        found_out_ff, found_out_in;
   logic [DATA_BITS-1:0]        addr_ff, addr_in;
   logic [COUNT_BITS-1:0]       offset;

   mbps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign csr_pready = 1'b1;

   // row of window cells, newest byte enters cell 0
   assign chain[0] = req_data_byte;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      if (i < MAX_PATTERN - 1) begin : g_mid
         mbps_cell u_cell (
            .clock    (clock),
            .shift_en (xfer),
            .byte_in  (chain[i]),
            .pat_byte (cfg.apat[i]),
            .care     (cfg.acare[i]),
            .byte_out (chain[i+1]),
            .hit      (hits[i])
         );
      end else begin : g_last
         // oldest byte leaves the row here
         mbps_cell u_cell (
            .clock    (clock),
            .shift_en (xfer),
            .byte_in  (chain[i]),
            .pat_byte (cfg.apat[i]),
            .care     (cfg.acare[i]),
            .byte_out (tail_byte),
            .hit      (hits[i])
         );
      end
   end

   // count bytes, saturating
   assign seen_next = (seen_ff == COUNT_MAX) ? seen_ff : seen_ff + COUNT_BITS'(1);

   assign matched = !found_ff && (seen_next >= COUNT_BITS'(cfg.eff_len)) && (&hits);
   assign produce = matched || (req_end_of_region && !found_ff);

   // a byte that gives no result never waits on the receiver
   assign req_ready = !rsp_valid_ff || rsp_ready || !produce;
   assign xfer      = req_valid && req_ready;

   assign offset = seen_next - COUNT_BITS'(cfg.eff_len);

   // region state: end of region starts afresh
   always_comb begin
      seen_in  = seen_ff;
      found_in = found_ff;
      if (xfer) begin
         if (req_end_of_region) begin
            seen_in  = '0;
            found_in = 1'b0;
         end else begin
            seen_in  = seen_next;
            found_in = found_ff || matched;
         end
      end
   end

   // output register: load on a result, drop on its transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_out_in = found_out_ff;
      addr_in      = addr_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (xfer && produce) begin
         rsp_valid_in = 1'b1;
         found_out_in = matched;
         addr_in      = matched ? cfg.base + DATA_BITS'(offset) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_out_ff <= found_out_in;
      addr_ff      <= addr_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_found   = found_out_ff;
   assign rsp_match_address = addr_ff;

endmodule

// ----- src/mbps_checker.sv -----
module mbps_checker import mbps_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_match_found,
   input logic [DATA_BITS-1:0] rsp_match_address
);

   // a waiting result holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_found)
         && $stable(rsp_match_address))
      else $error("result changed while stalled");

   // a not-found result carries a zero address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_found |-> rsp_match_address == '0)
      else $error("not-found result with non-zero address");

   // input only stalls behind a waiting, stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a pending result");

   // reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind masked_byte_pattern_scanner_core mbps_checker u_mbps_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_match_found   (rsp_match_found),
   .rsp_match_address (rsp_match_address)
);
